// File: design/ftpp_pkg.sv
// Package for the file transfer packet parser: transfer structs, control,
// TLV, item kind, packet kind and parse position codes. No dependencies.

package ftpp_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_packet;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  data_byte;
        logic [1:0]  packet_kind;
        logic        malformed;
        logic        truncated_data;
        logic        sequence_mismatch;
        logic        size_field_mismatch;
        logic        byte_count_mismatch;
        logic [31:0] file_size;
        logic        last_of_run;
    } out_item_t;

    localparam logic [7:0] CODE_DATA  = 8'h01;
    localparam logic [7:0] CODE_START = 8'h02;
    localparam logic [7:0] CODE_END   = 8'h03;
    localparam logic [7:0] TLV_SIZE   = 8'h00;
    localparam logic [7:0] TLV_NAME   = 8'h01;

    localparam logic [1:0] ITEM_PAYLOAD = 2'd0;
    localparam logic [1:0] ITEM_NAME    = 2'd1;
    localparam logic [1:0] ITEM_STATUS  = 2'd2;

    localparam logic [1:0] PKT_START   = 2'd0;
    localparam logic [1:0] PKT_DATA    = 2'd1;
    localparam logic [1:0] PKT_END     = 2'd2;
    localparam logic [1:0] PKT_UNKNOWN = 2'd3;

    localparam logic [3:0] POS_CONTROL = 4'd0;
    localparam logic [3:0] POS_TYPE    = 4'd1;
    localparam logic [3:0] POS_LENGTH  = 4'd2;
    localparam logic [3:0] POS_VALUE   = 4'd3;
    localparam logic [3:0] POS_SEQ     = 4'd4;
    localparam logic [3:0] POS_LEN_HI  = 4'd5;
    localparam logic [3:0] POS_LEN_LO  = 4'd6;
    localparam logic [3:0] POS_PAYLOAD = 4'd7;
    localparam logic [3:0] POS_SKIP    = 4'd8;

endpackage

// File: design/file_transfer_packet_parser_core.sv
// Top level of the file transfer packet parser: per-byte TLV parse state
// machine feeding a four-entry result queue. Depends on ftpp_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one packet byte per
//   transfer with a last-byte mark. Output channel (out_valid / out_stall /
//   out_data) carries payload bytes, filename bytes and one status result on
//   the last byte of each handled packet.
//   Each byte is parsed in the cycle it is accepted; its zero, one or two
//   results enter a four-entry registered queue that drives out_data.
//   Throughput is one byte per cycle while the receiver keeps up; a byte
//   that makes two results (final filename or payload byte) fills two queue
//   entries. The queue accepts a byte while it holds at most two results, so
//   in_stall rises only when the receiver stalls long enough to back it up.
//   A stalled output result holds until taken.
//   Reset empties the queue and returns the parser to waiting for a START
//   packet with all counters cleared.
//   SIZE_BITS sets the width of the gathered size fields (8 to 64).

module file_transfer_packet_parser_core #(
    parameter int SIZE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ftpp_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ftpp_pkg::out_item_t out_data
);

    localparam int CMP_W = (SIZE_BITS > 32) ? SIZE_BITS : 32;

    logic                 active_reg, active_next;
    logic [3:0]           pos_reg, pos_next;
    logic [1:0]           class_reg, class_next;
    logic [7:0]           tlv_reg, tlv_next;
    logic [15:0]          remain_reg, remain_next;
    logic [7:0]           len_hi_reg, len_hi_next;
    logic [7:0]           seq_reg, seq_next;
    logic [SIZE_BITS-1:0] announced_reg, announced_next;
    logic [SIZE_BITS-1:0] parsed_reg, parsed_next;
    logic [31:0]          total_reg, total_next;
    logic [15:0]          pkt_count_reg, pkt_count_next;
    logic                 err_reg, err_next;

    ftpp_pkg::out_item_t byte_res, stat_res;
    logic                byte_vld, stat_vld;

    logic [SIZE_BITS+7:0] shift_val;
    logic [CMP_W-1:0]     parsed_ext, announced_ext, total_ext;
    logic [32:0]          sum;
    logic                 mal;
    logic                 trunc;
    logic [7:0]           b;
    logic                 in_xfer;

    assign in_xfer = in_valid && !in_stall;
    assign b       = in_data.byte_value;

    always_comb
    begin
        active_next    = active_reg;
        pos_next       = pos_reg;
        class_next     = class_reg;
        tlv_next       = tlv_reg;
        remain_next    = remain_reg;
        len_hi_next    = len_hi_reg;
        seq_next       = seq_reg;
        announced_next = announced_reg;
        parsed_next    = parsed_reg;
        total_next     = total_reg;
        pkt_count_next = pkt_count_reg;
        err_next       = err_reg;
        byte_vld       = 1'b0;
        stat_vld       = 1'b0;
        byte_res       = '0;
        stat_res       = '0;
        shift_val      = {parsed_reg, b};
        mal            = 1'b0;
        trunc          = 1'b0;
        sum            = '0;
        parsed_ext     = '0;
        announced_ext  = CMP_W'(announced_reg);
        total_ext      = CMP_W'(total_reg);

        case (pos_reg)
            ftpp_pkg::POS_CONTROL:
            begin
                if (!active_reg)
                begin
                    if (b == ftpp_pkg::CODE_START)
                    begin
                        class_next  = ftpp_pkg::PKT_START;
                        parsed_next = '0;
                        pos_next    = ftpp_pkg::POS_TYPE;
                    end
                    else
                    begin
                        pos_next = ftpp_pkg::POS_SKIP;
                    end
                end
                else if (b == ftpp_pkg::CODE_DATA)
                begin
                    class_next     = ftpp_pkg::PKT_DATA;
                    err_next       = 1'b0;
                    pkt_count_next = '0;
                    remain_next    = '0;
                    seq_next       = seq_reg + 8'd1;
                    pos_next       = ftpp_pkg::POS_SEQ;
                end
                else if (b == ftpp_pkg::CODE_END)
                begin
                    class_next  = ftpp_pkg::PKT_END;
                    parsed_next = '0;
                    pos_next    = ftpp_pkg::POS_TYPE;
                end
                else
                begin
                    class_next = ftpp_pkg::PKT_UNKNOWN;
                    pos_next   = ftpp_pkg::POS_SKIP;
                end
            end
            ftpp_pkg::POS_TYPE:
            begin
                tlv_next = b;
                pos_next = ftpp_pkg::POS_LENGTH;
            end
            ftpp_pkg::POS_LENGTH:
            begin
                remain_next = {8'd0, b};
                pos_next    = (b != 8'd0) ? ftpp_pkg::POS_VALUE : ftpp_pkg::POS_TYPE;
            end
            ftpp_pkg::POS_VALUE:
            begin
                if (tlv_reg == ftpp_pkg::TLV_SIZE)
                begin
                    parsed_next = shift_val[SIZE_BITS-1:0];
                end
                else if (tlv_reg == ftpp_pkg::TLV_NAME)
                begin
                    byte_vld              = 1'b1;
                    byte_res.item_kind    = ftpp_pkg::ITEM_NAME;
                    byte_res.data_byte    = b;
                    byte_res.packet_kind  = class_reg;
                end
                remain_next = remain_reg - 16'd1;
                if (remain_next == 16'd0)
                begin
                    pos_next = ftpp_pkg::POS_TYPE;
                end
            end
            ftpp_pkg::POS_SEQ:
            begin
                if (b != (seq_reg - 8'd1))
                begin
                    err_next = 1'b1;
                end
                pos_next = ftpp_pkg::POS_LEN_HI;
            end
            ftpp_pkg::POS_LEN_HI:
            begin
                len_hi_next = b;
                pos_next    = ftpp_pkg::POS_LEN_LO;
            end
            ftpp_pkg::POS_LEN_LO:
            begin
                remain_next = {len_hi_reg, b};
                pos_next    = ftpp_pkg::POS_PAYLOAD;
            end
            ftpp_pkg::POS_PAYLOAD:
            begin
                if (remain_reg != 16'd0)
                begin
                    byte_vld             = 1'b1;
                    byte_res.item_kind   = ftpp_pkg::ITEM_PAYLOAD;
                    byte_res.data_byte   = b;
                    byte_res.packet_kind = class_reg;
                    remain_next          = remain_reg - 16'd1;
                    pkt_count_next       = pkt_count_reg + 16'd1;
                end
            end
            default:
            begin
            end
        endcase

        parsed_ext = CMP_W'(parsed_next);

        if (in_data.end_of_packet)
        begin
            if (pos_next >= ftpp_pkg::POS_TYPE && pos_next <= ftpp_pkg::POS_VALUE)
            begin
                mal                = (pos_next != ftpp_pkg::POS_TYPE);
                stat_vld           = 1'b1;
                stat_res.item_kind = ftpp_pkg::ITEM_STATUS;
                stat_res.malformed = mal;
                stat_res.file_size = parsed_ext[31:0];
                if (class_next == ftpp_pkg::PKT_START)
                begin
                    stat_res.packet_kind = ftpp_pkg::PKT_START;
                    if (!mal)
                    begin
                        active_next    = 1'b1;
                        announced_next = parsed_next;
                        total_next     = '0;
                        seq_next       = '0;
                    end
                end
                else
                begin
                    stat_res.packet_kind         = ftpp_pkg::PKT_END;
                    stat_res.size_field_mismatch = (parsed_next != announced_reg);
                    stat_res.byte_count_mismatch = (total_ext != announced_ext);
                    active_next                  = 1'b0;
                end
            end
            else if (pos_next >= ftpp_pkg::POS_SEQ && pos_next <= ftpp_pkg::POS_PAYLOAD)
            begin
                trunc = !(pos_next == ftpp_pkg::POS_PAYLOAD && remain_next == 16'd0);
                if (!trunc)
                begin
                    sum        = {1'b0, total_reg} + {17'd0, pkt_count_next};
                    total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                stat_vld                   = 1'b1;
                stat_res.item_kind         = ftpp_pkg::ITEM_STATUS;
                stat_res.packet_kind       = ftpp_pkg::PKT_DATA;
                stat_res.truncated_data    = trunc;
                stat_res.sequence_mismatch = err_next;
                stat_res.file_size         = total_next;
            end
            else if (active_reg)
            begin
                stat_vld             = 1'b1;
                stat_res.item_kind   = ftpp_pkg::ITEM_STATUS;
                stat_res.packet_kind = ftpp_pkg::PKT_UNKNOWN;
                stat_res.file_size   = total_reg;
            end
            pos_next = ftpp_pkg::POS_CONTROL;
        end

        byte_res.last_of_run = !stat_vld;
        stat_res.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= ftpp_pkg::POS_CONTROL;
            class_reg     <= '0;
            tlv_reg       <= '0;
            remain_reg    <= '0;
            len_hi_reg    <= '0;
            seq_reg       <= '0;
            announced_reg <= '0;
            parsed_reg    <= '0;
            total_reg     <= '0;
            pkt_count_reg <= '0;
            err_reg       <= 1'b0;
        end
        else if (in_xfer)
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            class_reg     <= class_next;
            tlv_reg       <= tlv_next;
            remain_reg    <= remain_next;
            len_hi_reg    <= len_hi_next;
            seq_reg       <= seq_next;
            announced_reg <= announced_next;
            parsed_reg    <= parsed_next;
            total_reg     <= total_next;
            pkt_count_reg <= pkt_count_next;
            err_reg       <= err_next;
        end
    end

    // result queue
    ftpp_pkg::out_item_t q_reg [4];
    logic [1:0]          wr_ptr_reg, wr_ptr_next;
    logic [1:0]          rd_ptr_reg, rd_ptr_next;
    logic [2:0]          count_reg, count_next;
    logic                push0, push1, pop;
    ftpp_pkg::out_item_t wdata0, wdata1;
    logic [1:0]          wr_ptr_p1;

    assign push0     = in_xfer && (byte_vld || stat_vld);
    assign push1     = in_xfer && byte_vld && stat_vld;
    assign wdata0    = byte_vld ? byte_res : stat_res;
    assign wdata1    = stat_res;
    assign wr_ptr_p1 = wr_ptr_reg + 2'd1;
    assign pop       = out_valid && !out_stall;

    assign out_valid = (count_reg != 3'd0);
    assign out_data  = q_reg[rd_ptr_reg];
    assign in_stall  = (count_reg > 3'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + {1'b0, push0} + {1'b0, push1};
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {2'd0, push0} + {2'd0, push1} - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (push0 && wr_ptr_reg == 2'(i))
            begin
                q_reg[i] <= wdata0;
            end
            else if (push1 && wr_ptr_p1 == 2'(i))
            begin
                q_reg[i] <= wdata1;
            end
        end
    end

endmodule

// File: design/ftpp_checker.sv
// Port-level checker for the file transfer packet parser and its bind.
// Depends on ftpp_pkg and file_transfer_packet_parser_core.

module ftpp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input ftpp_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input ftpp_pkg::out_item_t out_data
);

    // stalled output transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // stalled input transfer holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input changed while stalled");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.item_kind == ftpp_pkg::ITEM_STATUS
        |-> out_data.data_byte == 8'd0 && out_data.last_of_run)
        else $error("bad status result");

    a_byte_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.item_kind != ftpp_pkg::ITEM_STATUS
        |-> out_data.file_size == 32'd0 && !out_data.malformed
            && !out_data.truncated_data && !out_data.sequence_mismatch
            && !out_data.size_field_mismatch && !out_data.byte_count_mismatch)
        else $error("flags set on byte result");

    // input stalls only while the queue holds more than two results, so output is valid
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

endmodule

bind file_transfer_packet_parser_core ftpp_checker u_ftpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
